// ===== rtl/core/rna_pkg.sv =====
package rna_pkg;

    // fixed field widths
    localparam int RADIX_BITS = 5;
    localparam int FLAG_BITS  = 2;
    localparam int CHAR_BITS  = 8;
    localparam int DIGIT_BITS = 4;

    // format flag positions
    localparam int FLAG_UNSIGNED = 0;
    localparam int FLAG_LOWER    = 1;

    // legal base range, anything outside saturates
    localparam logic [RADIX_BITS-1:0] RADIX_MIN = 5'd2;
    localparam logic [RADIX_BITS-1:0] RADIX_MAX = 5'd16;

    // ascii codes
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS   = 8'h2d;
    localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [DIGIT_BITS-1:0] DIGIT_TEN   = 4'd10;

    // status from the serial divider to the sequencer
    typedef struct packed {
        logic done;
        logic quot_zero;
    } div_status_t;

    // one base-16 digit to its ascii character
    function automatic logic [CHAR_BITS-1:0] digit_char(
        input logic [DIGIT_BITS-1:0] digit,
        input logic                  lower
    );
        logic [CHAR_BITS-1:0] letter_base;
        logic [DIGIT_BITS-1:0] letter_ofs;
        letter_base = lower ? CHAR_LOWER_A : CHAR_UPPER_A;
        letter_ofs  = digit - DIGIT_TEN;
        if (digit < DIGIT_TEN)
        begin
            digit_char = CHAR_ZERO + {4'b0000, digit};
        end
        else
        begin
            digit_char = letter_base + {4'b0000, letter_ofs};
        end
    endfunction

endpackage

// ===== rtl/core/rna_in_if.sv =====
interface rna_in_if #(
    parameter int VALUE_BITS = 32
);
    logic                               valid;
    logic                               ready;
    logic signed [VALUE_BITS-1:0]       value;
    logic [rna_pkg::RADIX_BITS-1:0]     radix;
    logic [rna_pkg::FLAG_BITS-1:0]      format_flags;

    modport source (output valid, value, radix, format_flags, input ready);
    modport sink   (input valid, value, radix, format_flags, output ready);
endinterface

// ===== rtl/core/rna_out_if.sv =====
interface rna_out_if;
    logic                              valid;
    logic                              ready;
    logic [rna_pkg::CHAR_BITS-1:0]     character;
    logic                              last_char;

    modport source (output valid, character, last_char, input ready);
    modport sink   (input valid, character, last_char, output ready);
endinterface

// ===== rtl/core/rna_divider.sv =====
// restoring divider, one quotient bit per cycle, small variable divisor
module rna_divider #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [VALUE_BITS-1:0]               dividend,
    input  logic [rna_pkg::RADIX_BITS-1:0]      base,
    output logic [VALUE_BITS-1:0]               quotient,
    output logic [rna_pkg::DIGIT_BITS-1:0]      remainder,
    output rna_pkg::div_status_t                status
);
    localparam int CNT_W = $clog2(VALUE_BITS);
    localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(VALUE_BITS - 1);

    logic [VALUE_BITS-1:0]              q_reg, q_next;
    logic [rna_pkg::DIGIT_BITS-1:0]     rem_reg, rem_next;
    logic [rna_pkg::RADIX_BITS-1:0]     base_reg;
    logic [CNT_W-1:0]                   cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic                               nz_reg;
    logic [rna_pkg::RADIX_BITS-1:0]     trial;
    logic                               fits;

    function automatic logic [rna_pkg::DIGIT_BITS-1:0] rem_next_sub(
        input logic [rna_pkg::RADIX_BITS-1:0] t,
        input logic [rna_pkg::RADIX_BITS-1:0] b
    );
        logic [rna_pkg::RADIX_BITS-1:0] diff;
        diff = t - b;
        rem_next_sub = diff[rna_pkg::DIGIT_BITS-1:0];
    endfunction

    // shift next dividend bit into the partial remainder
    assign trial = {rem_reg, q_reg[VALUE_BITS-1]};
    assign fits  = (trial >= base_reg);

    always_comb
    begin
        rem_next = fits ? rem_next_sub(trial, base_reg) : trial[rna_pkg::DIGIT_BITS-1:0];
        q_next   = {q_reg[VALUE_BITS-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            nz_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                nz_reg   <= 1'b0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                nz_reg  <= nz_reg | fits;
                if (cnt_reg == LAST_BIT)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= dividend;
            rem_reg  <= '0;
            base_reg <= base;
        end
        else if (busy_reg)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient         = q_reg;
    assign remainder        = rem_reg;
    assign status.done      = done_reg;
    assign status.quot_zero = !nz_reg;

endmodule

// ===== rtl/core/radix_number_to_ascii.sv =====
// radix_number_to_ascii: prints one integer as ascii text in base 2..16
// channels: number (sink) takes value, radix and format_flags; text (source)
//   gives one character per transfer, most significant first, last_char set
//   on the final character; a negative signed value is preceded by '-'
// radix below 2 is taken as 2, above 16 as 16; format_flags bit0 reads the
//   value as unsigned, bit1 selects lowercase letters
// timing: each digit takes one full run of the bit-serial divider, and the
//   first character shows only after the last digit is found; then one
//   character per cycle while text is ready (up to 33 characters for a
//   32-bit value in base 2)
// one item at a time: number.ready is high only while the sequencer is idle;
//   it rises again once the final character sits in the output register
// a stalled text receiver simply holds the output register and the digit stack
// reset clears the sequencer and the output register; no item survives it
module radix_number_to_ascii #(
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    rna_in_if.sink      number,
    rna_out_if.source   text
);
    localparam int DCNT_W = $clog2(VALUE_BITS + 1);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]                             state_reg, state_next;
    logic [DCNT_W-1:0]                      cnt_reg, cnt_next;
    logic                                   sign_pend_reg, sign_pend_next;
    logic                                   lower_reg;
    logic [rna_pkg::RADIX_BITS-1:0]         base_reg;
    logic                                   out_valid_reg, out_valid_next;
    logic [rna_pkg::CHAR_BITS-1:0]          char_reg, char_next;
    logic                                   last_reg, last_next;
    logic [rna_pkg::DIGIT_BITS-1:0]         stk_reg [VALUE_BITS];

    logic                                   accept;
    logic                                   slot_free;
    logic                                   push;
    logic                                   pop;
    logic                                   div_start;
    logic [VALUE_BITS-1:0]                  raw_in;
    logic [VALUE_BITS-1:0]                  mag_in;
    logic                                   neg_in;
    logic [rna_pkg::RADIX_BITS-1:0]         base_in;
    logic [rna_pkg::RADIX_BITS-1:0]         div_base;
    logic [VALUE_BITS-1:0]                  dividend;
    logic [VALUE_BITS-1:0]                  quotient;
    logic [rna_pkg::DIGIT_BITS-1:0]         remainder;
    rna_pkg::div_status_t                   div_stat;

    assign accept    = number.valid && number.ready;
    assign slot_free = !out_valid_reg || text.ready;

    // magnitude of the input; the most negative value wraps to 2^(n-1) as wanted
    assign raw_in = number.value;
    assign neg_in = !number.format_flags[rna_pkg::FLAG_UNSIGNED] && raw_in[VALUE_BITS-1];
    assign mag_in = neg_in ? (~raw_in + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw_in;

    always_comb
    begin
        if (number.radix < rna_pkg::RADIX_MIN)
            base_in = rna_pkg::RADIX_MIN;
        else if (number.radix > rna_pkg::RADIX_MAX)
            base_in = rna_pkg::RADIX_MAX;
        else
            base_in = number.radix;
    end

    // chain divisions: each quotient feeds the next digit, same base throughout
    assign push      = (state_reg == ST_DIV) && div_stat.done;
    assign div_start = accept || (push && !div_stat.quot_zero);
    assign dividend  = accept ? mag_in : quotient;
    assign div_base  = accept ? base_in : base_reg;

    rna_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (dividend),
        .base      (div_base),
        .quotient  (quotient),
        .remainder (remainder),
        .status    (div_stat)
    );

    // pop a digit when the output slot frees up and the sign is out
    assign pop = (state_reg == ST_EMIT) && slot_free && !sign_pend_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sign_pend_next = sign_pend_reg;
        out_valid_next = out_valid_reg && !text.ready;
        char_next      = char_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next     = ST_DIV;
                    cnt_next       = '0;
                    sign_pend_next = neg_in;
                end
            end
            ST_DIV:
            begin
                if (push)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (div_stat.quot_zero)
                        state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    if (sign_pend_reg)
                    begin
                        char_next      = rna_pkg::CHAR_MINUS;
                        last_next      = 1'b0;
                        sign_pend_next = 1'b0;
                    end
                    else
                    begin
                        char_next = rna_pkg::digit_char(stk_reg[0], lower_reg);
                        last_next = (cnt_reg == DCNT_W'(1));
                        cnt_next  = cnt_reg - 1'b1;
                        if (cnt_reg == DCNT_W'(1))
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            sign_pend_reg <= sign_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
        if (accept)
        begin
            lower_reg <= number.format_flags[rna_pkg::FLAG_LOWER];
            base_reg  <= base_in;
        end
    end

    // digit stack: least significant digit pushed first, top is the next to print
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stk_reg[0] <= remainder;
            for (int i = 1; i < VALUE_BITS; i++)
                stk_reg[i] <= stk_reg[i-1];
        end
        else if (pop)
        begin
            for (int i = 0; i < VALUE_BITS - 1; i++)
                stk_reg[i] <= stk_reg[i+1];
        end
    end

    assign number.ready   = (state_reg == ST_IDLE);
    assign text.valid     = out_valid_reg;
    assign text.character = char_reg;
    assign text.last_char = last_reg;

    // a new item always starts a division
    a_accept_divides: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_DIV))
        else $error("accepted item did not enter division");

    // printing never starts with an empty stack
    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (cnt_reg != '0))
        else $error("emit phase with empty digit stack");

    // the stack never holds more digits than the value has bits
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DCNT_W'(VALUE_BITS))
        else $error("digit stack overflow");

    // the divider only reports during the division phase
    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_DIV))
        else $error("divider finished outside division phase");

    // the sign never goes out as the final character
    a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (char_reg == rna_pkg::CHAR_MINUS)) |-> !last_reg)
        else $error("minus sign flagged as last character");

endmodule

// ===== test/radix_number_to_ascii_tb.sv =====
`timescale 1ns / 100ps

module radix_number_to_ascii_tb;

    localparam int VALUE_BITS    = 32;
    localparam int RANDOM_ITEMS  = 306;
    // worst single item: 32 digits, each a full divider run, plus output
    localparam int DRAIN_CYCLES  = 2200;
    // several times the slowest legal run, pressure stall included
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int HOLD_CYCLES   = 2500;

    typedef struct {
        logic [VALUE_BITS-1:0]          value;
        logic [rna_pkg::RADIX_BITS-1:0] radix;
        logic [rna_pkg::FLAG_BITS-1:0]  flags;
    } number_item_t;

    typedef struct {
        logic [rna_pkg::CHAR_BITS-1:0] character;
        logic                          last_char;
    } text_char_t;

    logic clk;
    logic rst_n;

    rna_in_if #(.VALUE_BITS(VALUE_BITS)) number_bus ();
    rna_out_if                           text_bus ();

    radix_number_to_ascii #(
        .VALUE_BITS(VALUE_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .number (number_bus),
        .text   (text_bus)
    );

    // numbers waiting to be offered, characters waiting to come out
    number_item_t pending_numbers [$];
    text_char_t   expected_text [$];
    number_item_t next_number;

    int total_numbers = 1;
    int numbers_taken = 0;
    int error_count   = 0;
    int cycle_count   = 0;
    int hold_left     = 0;
    bit hold_done     = 1'b0;
    // set at the rising edge of a number transfer, cleared by the driver
    bit number_taken  = 1'b0;

    // free-running clock, 10 ns period
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // -------------------------------------------------------------------
    // text predictor: digits of the magnitude, most significant first
    // -------------------------------------------------------------------
    task automatic spell_number(
        input logic [VALUE_BITS-1:0]          raw,
        input logic [rna_pkg::RADIX_BITS-1:0] radix,
        input logic [rna_pkg::FLAG_BITS-1:0]  flags
    );
        logic [VALUE_BITS-1:0]         mag;
        logic [VALUE_BITS-1:0]         base;
        logic [VALUE_BITS-1:0]         digit;
        logic [rna_pkg::CHAR_BITS-1:0] glyph;
        logic [rna_pkg::CHAR_BITS-1:0] digits [$];
        text_char_t                    ch;

        // out-of-range bases clamp to the nearest legal one
        if (radix < rna_pkg::RADIX_MIN)
        begin
            base = VALUE_BITS'(rna_pkg::RADIX_MIN);
        end
        else if (radix > rna_pkg::RADIX_MAX)
        begin
            base = VALUE_BITS'(rna_pkg::RADIX_MAX);
        end
        else
        begin
            base = VALUE_BITS'(radix);
        end

        mag = raw;
        // signed negative: minus sign, then magnitude; the most negative
        // value negates onto itself, which is already the right magnitude
        if (!flags[rna_pkg::FLAG_UNSIGNED] && raw[VALUE_BITS-1])
        begin
            mag = -raw;
            ch.character = rna_pkg::CHAR_MINUS;
            ch.last_char = 1'b0;
            expected_text.push_back(ch);
        end

        // zero still yields a single '0'
        do
        begin
            digit = mag % base;
            if (digit < 10)
            begin
                glyph = rna_pkg::CHAR_ZERO + digit[rna_pkg::CHAR_BITS-1:0];
            end
            else
            begin
                glyph = (flags[rna_pkg::FLAG_LOWER] ? rna_pkg::CHAR_LOWER_A
                                                    : rna_pkg::CHAR_UPPER_A)
                        + digit[rna_pkg::CHAR_BITS-1:0] - 8'd10;
            end
            digits.push_front(glyph);
            mag = mag / base;
        end
        while (mag != 0);

        foreach (digits[i])
        begin
            ch.character = digits[i];
            ch.last_char = (i == digits.size() - 1);
            expected_text.push_back(ch);
        end
    endtask

    task automatic queue_number(
        input logic [VALUE_BITS-1:0]          value,
        input logic [rna_pkg::RADIX_BITS-1:0] radix,
        input logic [rna_pkg::FLAG_BITS-1:0]  flags
    );
        number_item_t item;
        item.value = value;
        item.radix = radix;
        item.flags = flags;
        pending_numbers.push_back(item);
    endtask

    // idle share in percent for the current third of the run:
    // sender 33 / receiver 88, then swapped, then no idling
    function automatic int idle_percent(input bit for_sender);
        int phase;
        phase = numbers_taken * 3 / total_numbers;
        case (phase)
            0:       return for_sender ? 33 : 88;
            1:       return for_sender ? 88 : 33;
            default: return 0;
        endcase
    endfunction

    // -------------------------------------------------------------------
    // stimulus and end of run
    // -------------------------------------------------------------------
    initial
    begin
        logic [VALUE_BITS-1:0]          v;
        logic [rna_pkg::RADIX_BITS-1:0] r;
        int                             base;

        // every input known from time zero, reset held low
        rst_n                   = 1'b0;
        number_bus.valid        = 1'b0;
        number_bus.value        = '0;
        number_bus.radix        = rna_pkg::RADIX_MIN;
        number_bus.format_flags = '0;
        text_bus.ready          = 1'b0;

        // directed: zero, extremes, all flag combinations, clamped bases
        queue_number(32'd0,          5'd10, 2'b00);
        queue_number(32'd0,          5'd2,  2'b01);
        queue_number(32'd1,          5'd2,  2'b00);
        queue_number(32'hFFFFFFFF,   5'd10, 2'b00);
        queue_number(32'hFFFFFFFF,   5'd16, 2'b01);
        queue_number(32'hFFFFFFFF,   5'd16, 2'b11);
        queue_number(32'hFFFFFFFF,   5'd2,  2'b01);
        // most negative value, signed, in base 2: the longest text
        queue_number(32'h80000000,   5'd2,  2'b00);
        queue_number(32'h80000000,   5'd16, 2'b01);
        queue_number(32'h80000000,   5'd10, 2'b10);
        queue_number(32'h7FFFFFFF,   5'd10, 2'b00);
        queue_number(32'h7FFFFFFF,   5'd16, 2'b10);
        queue_number(32'h00ABCDEF,   5'd16, 2'b00);
        queue_number(32'h00ABCDEF,   5'd16, 2'b10);
        queue_number(-32'sh00ABCDEF, 5'd16, 2'b10);
        // bases below two and above sixteen clamp
        queue_number(32'd5,          5'd0,  2'b00);
        queue_number(-32'sd6,        5'd1,  2'b00);
        queue_number(32'd255,        5'd17, 2'b00);
        queue_number(32'h0000FACE,   5'd31, 2'b10);
        queue_number(32'd3486784401, 5'd3,  2'b01);
        queue_number(32'd14,         5'd15, 2'b00);
        queue_number(32'd11,         5'd12, 2'b10);
        queue_number(-32'sd823543,   5'd7,  2'b00);
        queue_number(32'd12345678,   5'd9,  2'b11);

        // random: mostly full-width and small values, some edges and powers
        repeat (RANDOM_ITEMS)
        begin
            if ($urandom_range(4) == 0)
            begin
                r = rna_pkg::RADIX_BITS'($urandom_range(31));
            end
            else
            begin
                r = rna_pkg::RADIX_BITS'($urandom_range(16, 2));
            end
            base = (r < 2) ? 2 : (r > 16) ? 16 : int'(r);
            case ($urandom_range(9))
                0, 1, 2, 3:
                begin
                    v = $urandom();
                end
                4, 5, 6:
                begin
                    v = $urandom_range(999);
                    if ($urandom_range(1))
                    begin
                        v = -v;
                    end
                end
                7:
                begin
                    case ($urandom_range(5))
                        0:       v = 32'h80000000;
                        1:       v = 32'h7FFFFFFF;
                        2:       v = 32'hFFFFFFFF;
                        3:       v = 32'h80000001;
                        4:       v = 32'd1;
                        default: v = 32'd0;
                    endcase
                end
                default:
                begin
                    // power of the base, nudged by one: digit rollover
                    v = 1;
                    repeat ($urandom_range(31))
                    begin
                        v = v * base;
                    end
                    v = v + $urandom_range(2) - 1;
                    if ($urandom_range(3) == 0)
                    begin
                        v = -v;
                    end
                end
            endcase
            queue_number(v, r, rna_pkg::FLAG_BITS'($urandom_range(3)));
        end
        total_numbers = pending_numbers.size();

        // reset held low, then released away from the rising edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // every number taken and every character seen
        while (numbers_taken < total_numbers || expected_text.size() != 0)
        begin
            @(posedge clk);
        end
        // quiet period to catch stray characters
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // -------------------------------------------------------------------
    // number driver: inputs change on the falling edge
    // -------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (number_bus.valid && !number_taken)
            begin
                // offer stays up until the transfer happens
            end
            else if (pending_numbers.size() != 0
                     && $urandom_range(99) >= idle_percent(1'b1))
            begin
                next_number = pending_numbers.pop_front();
                number_bus.valid        <= 1'b1;
                number_bus.value        <= next_number.value;
                number_bus.radix        <= next_number.radix;
                number_bus.format_flags <= next_number.flags;
            end
            else
            begin
                number_bus.valid <= 1'b0;
            end
            number_taken = 1'b0;
        end
    end

    // number monitor: each transfer extends the expected text
    always @(posedge clk)
    begin
        if (rst_n && number_bus.valid && number_bus.ready)
        begin
            spell_number(number_bus.value, number_bus.radix, number_bus.format_flags);
            numbers_taken = numbers_taken + 1;
            number_taken  = 1'b1;
        end
    end

    // -------------------------------------------------------------------
    // text receiver: random stalls plus one long hold-off
    // -------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            text_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= idle_percent(1'b0));
        end
    end

    // long hold-off once the run enters its no-idle third; the sender keeps
    // offering, so the block backs up and drops number.ready
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
            end
            else if (!hold_done && numbers_taken * 3 >= total_numbers * 2)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
        end
    end

    // text monitor: compare each character transfer with the oldest expected
    always @(posedge clk)
    begin
        text_char_t want;
        if (rst_n && text_bus.valid && text_bus.ready)
        begin
            if (expected_text.size() == 0)
            begin
                $display("%0t: unexpected character 0x%02h last=%0b", $time,
                         text_bus.character, text_bus.last_char);
                error_count = error_count + 1;
            end
            else
            begin
                want = expected_text.pop_front();
                if (text_bus.character !== want.character)
                begin
                    $display("%0t: character expected 0x%02h got 0x%02h", $time,
                             want.character, text_bus.character);
                    error_count = error_count + 1;
                end
                if (text_bus.last_char !== want.last_char)
                begin
                    $display("%0t: last_char expected %0b got %0b", $time,
                             want.last_char, text_bus.last_char);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

endmodule
